// ===== sv/vgf_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// vgf_pkg: shared types and constants of the vertical gradient filter
// Field widths, register indexes and the item records passed between the
// front end, the queues and the back end.
// ---------------------------------------------------------------------------
package vgf_pkg;

    localparam int PIX_W     = 8;
    localparam int POS_W     = 10;
    localparam int CFG_W     = 11;
    localparam int CFG_IDX_W = 2;
    localparam int LINE_W    = 2 * PIX_W;
    localparam int MIN_SIZE  = 3;

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

    // Reset value of both size registers
    localparam logic [CFG_W-1:0] SIZE_RESET = 11'd1024;

    // Depth of the queue between front and back, and of the result queue
    localparam int MID_DEPTH = 2;
    localparam int OUT_DEPTH = 2;

    // Classified input item, as the back end needs it
    typedef struct packed {
        logic             emit;      // item produces a result
        logic             interior;  // result centre is not on the top row or left column
        logic             last;      // result is the last of the frame
        logic [POS_W-1:0] out_row;
        logic [POS_W-1:0] out_col;
        logic [PIX_W-1:0] pixel;
    } vgf_tag_t;

    // Result item
    typedef struct packed {
        logic [PIX_W-1:0] value;
        logic [POS_W-1:0] out_row;
        logic [POS_W-1:0] out_col;
        logic             frame_last;
    } vgf_result_t;

endpackage

// ===== sv/vgf_fifo.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// vgf_fifo: small register queue
// Holds up to DEPTH items; full and empty come straight from the fill count.
// ---------------------------------------------------------------------------
module vgf_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] entries_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = entries_reg[rd_ptr_reg];

    // Store the pushed item
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entries_reg[wr_ptr_reg] <= wdata;
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ===== sv/vgf_front.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// vgf_front: position tracking and item classification
// Holds the size registers and the row/column counters, places each pixel
// in the frame and tags it with what the back end must produce for it.
// ---------------------------------------------------------------------------
module vgf_front #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write,
    input  logic [vgf_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [vgf_pkg::CFG_W-1:0]         cfg_data,
    input  logic                              accept,
    input  logic [vgf_pkg::PIX_W-1:0]         pixel,
    input  logic                              frame_start,
    output logic [$clog2(MAX_WIDTH)-1:0]      item_addr,
    output vgf_pkg::vgf_tag_t                 item_tag
);

    import vgf_pkg::*;

    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int RW  = $clog2(MAX_HEIGHT);
    localparam int SWW = (CFG_W > CW + 1) ? CFG_W : CW + 1;
    localparam int SHW = (CFG_W > RW + 1) ? CFG_W : RW + 1;

    logic [CFG_W-1:0] image_width_reg;
    logic [CFG_W-1:0] image_height_reg;
    logic [CW-1:0]    col_reg;
    logic [CW-1:0]    col_next;
    logic [RW-1:0]    row_reg;
    logic [RW-1:0]    row_next;

    logic [SWW-1:0]   w_cfg;
    logic [SWW-1:0]   w_lim;
    logic [SHW-1:0]   h_cfg;
    logic [SHW-1:0]   h_lim;
    logic [CW-1:0]    c_start;
    logic [RW-1:0]    r_start;
    logic [CW-1:0]    c_cur;
    logic [RW-1:0]    r_cur;
    logic [SWW-1:0]   c_inc;
    logic [SHW-1:0]   r_inc;

    // Limit the sizes to the supported range
    assign w_cfg = SWW'(image_width_reg);
    assign h_cfg = SHW'(image_height_reg);
    assign w_lim = (w_cfg < SWW'(MIN_SIZE)) ? SWW'(MIN_SIZE) :
                   (w_cfg > SWW'(MAX_WIDTH)) ? SWW'(MAX_WIDTH) : w_cfg;
    assign h_lim = (h_cfg < SHW'(MIN_SIZE)) ? SHW'(MIN_SIZE) :
                   (h_cfg > SHW'(MAX_HEIGHT)) ? SHW'(MAX_HEIGHT) : h_cfg;

    // Place the pixel: restart on frame start, wrap counters past the size
    assign c_start = frame_start ? '0 : col_reg;
    assign r_start = frame_start ? '0 : row_reg;
    assign c_cur   = (SWW'(c_start) >= w_lim) ? '0 : c_start;
    assign r_cur   = (SHW'(r_start) >= h_lim) ? '0 : r_start;
    assign c_inc   = SWW'(c_cur) + SWW'(1);
    assign r_inc   = SHW'(r_cur) + SHW'(1);

    // Step to the next position
    always_comb
    begin
        col_next = CW'(c_inc);
        row_next = r_cur;
        if (c_inc >= w_lim)
        begin
            col_next = '0;
            row_next = (r_inc >= h_lim) ? '0 : RW'(r_inc);
        end
    end

    // Tag the item
    assign item_addr         = c_cur;
    assign item_tag.emit     = (r_cur != '0) && (c_cur != '0);
    assign item_tag.interior = (r_cur > RW'(1)) && (c_cur > CW'(1));
    assign item_tag.last     = (SHW'(r_cur) == h_lim - SHW'(1)) &&
                               (SWW'(c_cur) == w_lim - SWW'(1));
    assign item_tag.out_row  = POS_W'(r_cur - RW'(1));
    assign item_tag.out_col  = POS_W'(c_cur - CW'(1));
    assign item_tag.pixel    = pixel;

    // Hold size registers and position counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg  <= SIZE_RESET;
            image_height_reg <= SIZE_RESET;
            col_reg          <= '0;
            row_reg          <= '0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_IMAGE_WIDTH:  image_width_reg  <= cfg_data;
                    REG_IMAGE_HEIGHT: image_height_reg <= cfg_data;
                    default:          ;
                endcase
            end
            if (accept)
            begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
        end
    end

endmodule

// ===== sv/vgf_back.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// vgf_back: line store, windows and gradient
// Reads the line store entry of each item's column, updates the two
// three-pixel windows and forms the gradient result.
// ---------------------------------------------------------------------------
module vgf_back #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic [$clog2(MAX_WIDTH)-1:0]  in_addr,
    input  vgf_pkg::vgf_tag_t             in_tag,
    output logic                          in_pop,
    input  logic                          out_full,
    output logic                          out_push,
    output vgf_pkg::vgf_result_t          out_result,
    output logic                          clr_busy
);

    import vgf_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);

    logic [LINE_W-1:0]  line_mem [MAX_WIDTH];
    logic [LINE_W-1:0]  rd_data_reg;
    logic               byp_hit_reg;
    logic [LINE_W-1:0]  byp_data_reg;
    logic               clr_busy_reg;
    logic [CW-1:0]      clr_addr_reg;
    logic               b_valid_reg;
    logic [CW-1:0]      b_addr_reg;
    vgf_tag_t           b_tag_reg;
    logic [2*PIX_W-1:0] win_top_reg;
    logic [2*PIX_W-1:0] win_bot_reg;

    logic               b_fire;
    logic               b_load;
    logic [LINE_W-1:0]  entry;
    logic [LINE_W-1:0]  wr_data;
    logic [3*PIX_W-1:0] top_new;
    logic [3*PIX_W-1:0] bot_new;
    logic [PIX_W+1:0]   sum_top;
    logic [PIX_W+1:0]   sum_bot;
    logic [PIX_W+2:0]   grad;

    function automatic logic [PIX_W+1:0] wsum(input logic [3*PIX_W-1:0] win);
        return {2'b00, win[3*PIX_W-1:2*PIX_W]} + {1'b0, win[2*PIX_W-1:PIX_W], 1'b0}
             + {2'b00, win[PIX_W-1:0]};
    endfunction

    // Move an item into the stage when it is free or leaving
    assign b_fire   = b_valid_reg && (!b_tag_reg.emit || !out_full);
    assign b_load   = in_valid && !clr_busy_reg && (!b_valid_reg || b_fire);
    assign in_pop   = b_load;
    assign clr_busy = clr_busy_reg;

    // Take the entry written in the same cycle as the read when addresses match
    assign entry   = byp_hit_reg ? byp_data_reg : rd_data_reg;
    assign wr_data = {entry[PIX_W-1:0], b_tag_reg.pixel};
    assign top_new = {win_top_reg, entry[LINE_W-1:PIX_W]};
    assign bot_new = {win_bot_reg, b_tag_reg.pixel};

    // Form the gradient; drop it to zero outside 0..255 or on the border
    assign sum_top = wsum(top_new);
    assign sum_bot = wsum(bot_new);
    assign grad    = {1'b0, sum_bot} - {1'b0, sum_top};

    assign out_push              = b_fire && b_tag_reg.emit;
    assign out_result.value      = (b_tag_reg.interior && (grad[PIX_W+2:PIX_W] == '0)) ?
                                   grad[PIX_W-1:0] : '0;
    assign out_result.out_row    = b_tag_reg.out_row;
    assign out_result.out_col    = b_tag_reg.out_col;
    assign out_result.frame_last = b_tag_reg.last;

    // Line store: clear after reset, then write back and read ahead
    always_ff @(posedge clk)
    begin
        if (clr_busy_reg)
        begin
            line_mem[clr_addr_reg] <= '0;
        end
        else if (b_fire)
        begin
            line_mem[b_addr_reg] <= wr_data;
        end
        if (b_load)
        begin
            rd_data_reg <= line_mem[in_addr];
        end
    end

    // Capture the item payload and the same-cycle write for bypass
    always_ff @(posedge clk)
    begin
        if (b_load)
        begin
            b_addr_reg   <= in_addr;
            b_tag_reg    <= in_tag;
            byp_data_reg <= wr_data;
        end
    end

    // Control: clearing pass, stage valid, bypass flag, windows
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
            b_valid_reg  <= 1'b0;
            byp_hit_reg  <= 1'b0;
            win_top_reg  <= '0;
            win_bot_reg  <= '0;
        end
        else
        begin
            if (clr_busy_reg)
            begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
                if (clr_addr_reg == CW'(MAX_WIDTH - 1))
                begin
                    clr_busy_reg <= 1'b0;
                end
            end
            if (b_load)
            begin
                b_valid_reg <= 1'b1;
                byp_hit_reg <= b_fire && (b_addr_reg == in_addr);
            end
            else if (b_fire)
            begin
                b_valid_reg <= 1'b0;
            end
            if (b_fire)
            begin
                win_top_reg <= top_new[2*PIX_W-1:0];
                win_bot_reg <= bot_new[2*PIX_W-1:0];
            end
        end
    end

endmodule

// ===== sv/vertical_gradient_3x3_filter.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// vertical_gradient_3x3_filter: 3x3 vertical gradient on a pixel stream
// Pixels enter in raster order; each pixel at row and column >= 1 yields
// the result for the centre one row up and one column left.
// ---------------------------------------------------------------------------
// Usage:
//   Input queue: drive pixel and frame_start with push; the item is taken
//   on a clock edge where push is high and full is low.
//   Result queue: while empty is low, value, out_row, out_col and
//   frame_last show the oldest result; pop takes it.
//   Configuration: cfg_write with cfg_index/cfg_data sets image_width (0)
//   or image_height (1); write only while no item is in flight.
//   Throughput: one item per cycle unless stalled; the line store takes one
//   read and one write per cycle; each item reads and writes its column once.
//   Path: a pixel passes the front queue, then the line store read and the
//   gradient stage, into the result queue that drives the result ports.
//   Reset: the line store is cleared one entry per cycle, so full stays high
//   until all MAX_WIDTH entries are clear; configuration writes still land.
//   Stall: when pop is held low the two-entry result queue fills, then the
//   gradient stage and the two-entry front queue, and full rises.
// ---------------------------------------------------------------------------
module vertical_gradient_3x3_filter #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_write,
    input  logic [vgf_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [vgf_pkg::CFG_W-1:0]     cfg_data,
    input  logic                          push,
    output logic                          full,
    input  logic [vgf_pkg::PIX_W-1:0]     pixel,
    input  logic                          frame_start,
    output logic                          empty,
    input  logic                          pop,
    output logic [vgf_pkg::PIX_W-1:0]     value,
    output logic [vgf_pkg::POS_W-1:0]     out_row,
    output logic [vgf_pkg::POS_W-1:0]     out_col,
    output logic                          frame_last
);

    import vgf_pkg::*;

    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int TAG_W = $bits(vgf_tag_t);
    localparam int MID_W = CW + TAG_W;
    localparam int RES_W = $bits(vgf_result_t);

    logic              accept;
    logic              mid_full;
    logic              mid_empty;
    logic [CW-1:0]     front_addr;
    vgf_tag_t          front_tag;
    logic [MID_W-1:0]  mid_rdata;
    logic [CW-1:0]     back_addr;
    vgf_tag_t          back_tag;
    logic              back_pop;
    logic              res_push;
    logic              res_full;
    vgf_result_t       back_result;
    logic [RES_W-1:0]  res_rdata;
    vgf_result_t       res_head;
    logic              clr_busy;

    // Hold off input while the line store is cleared
    assign full   = mid_full || clr_busy;
    assign accept = push && !full;

    vgf_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .accept      (accept),
        .pixel       (pixel),
        .frame_start (frame_start),
        .item_addr   (front_addr),
        .item_tag    (front_tag)
    );

    vgf_fifo #(
        .WIDTH (MID_W),
        .DEPTH (MID_DEPTH)
    ) u_mid_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (accept),
        .wdata ({front_addr, front_tag}),
        .full  (mid_full),
        .pop   (back_pop),
        .rdata (mid_rdata),
        .empty (mid_empty)
    );

    assign back_addr = mid_rdata[MID_W-1 -: CW];
    assign back_tag  = vgf_tag_t'(mid_rdata[TAG_W-1:0]);

    vgf_back #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (!mid_empty),
        .in_addr    (back_addr),
        .in_tag     (back_tag),
        .in_pop     (back_pop),
        .out_full   (res_full),
        .out_push   (res_push),
        .out_result (back_result),
        .clr_busy   (clr_busy)
    );

    vgf_fifo #(
        .WIDTH (RES_W),
        .DEPTH (OUT_DEPTH)
    ) u_res_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .wdata (back_result),
        .full  (res_full),
        .pop   (pop),
        .rdata (res_rdata),
        .empty (empty)
    );

    // Present the oldest result
    assign res_head   = vgf_result_t'(res_rdata);
    assign value      = res_head.value;
    assign out_row    = res_head.out_row;
    assign out_col    = res_head.out_col;
    assign frame_last = res_head.frame_last;

endmodule

// ===== sv/vgf_checker.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// vgf_checker: port-level checks of the vertical gradient filter
// Watches the result queue for stable heads, zero borders and the order
// of positions from one result to the next.
// ---------------------------------------------------------------------------
module vgf_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          empty,
    input logic                          pop,
    input logic [vgf_pkg::PIX_W-1:0]     value,
    input logic [vgf_pkg::POS_W-1:0]     out_row,
    input logic [vgf_pkg::POS_W-1:0]     out_col,
    input logic                          frame_last
);

    import vgf_pkg::*;

    // Hold a waiting result until it is taken
    a_head_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(value) && $stable(out_row) &&
                              $stable(out_col) && $stable(frame_last)))
        else $error("result changed while waiting");

    // Border results carry zero
    a_border_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && (out_row == '0 || out_col == '0)) |-> (value == '0))
        else $error("nonzero value on border");

    // After the last result of a frame the next one is on row zero
    a_frame_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && pop && frame_last) |=> (empty || out_row == '0))
        else $error("result after frame end not on row zero");

    // Columns advance by one or restart at zero
    a_col_order: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && pop) |=> (empty || out_col == '0 ||
                             out_col == $past(out_col) + POS_W'(1)))
        else $error("column order broken");

endmodule

bind vertical_gradient_3x3_filter vgf_checker u_vgf_checker (.*);
